FILE: rtl/e2q_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared widths, constants and the arctangent table for the Euler angle to
// quaternion pipeline.
// ----------------------------------------------------------------------------
package e2q_pkg;

  // Angle and output formats.
  localparam int ANGLE_BITS = 16;
  localparam int FRAC_BITS  = 15;
  localparam int FIELD_W    = 16;

  // Rotation engine formats: Q2.30 sine and cosine, angle in 2^32 per turn.
  localparam int STEPS      = 30;
  localparam int WORK_FRAC  = 30;
  localparam int XW         = 32;
  localparam int ZW         = 34;
  localparam int PW         = 2 * XW;
  localparam int SW         = PW + 1;
  localparam int FIN_SHIFT  = 2 * WORK_FRAC - FRAC_BITS;
  localparam int SAT_LIM    = (1 << FRAC_BITS) - 1;

  localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(652032874);

  // Arctangent of 2^-i in units of 2^32 per full turn.
  function automatic logic signed [ZW-1:0] atan_step(input int idx);
    logic [31:0] v;
    begin
      case (idx)
        0:  v = 32'd536870912;
        1:  v = 32'd316933406;
        2:  v = 32'd167458907;
        3:  v = 32'd85004756;
        4:  v = 32'd42667331;
        5:  v = 32'd21354465;
        6:  v = 32'd10679838;
        7:  v = 32'd5340245;
        8:  v = 32'd2670163;
        9:  v = 32'd1335087;
        10: v = 32'd667544;
        11: v = 32'd333772;
        12: v = 32'd166886;
        13: v = 32'd83443;
        14: v = 32'd41722;
        15: v = 32'd20861;
        16: v = 32'd10430;
        17: v = 32'd5215;
        18: v = 32'd2608;
        19: v = 32'd1304;
        20: v = 32'd652;
        21: v = 32'd326;
        22: v = 32'd163;
        23: v = 32'd81;
        24: v = 32'd41;
        25: v = 32'd20;
        26: v = 32'd10;
        27: v = 32'd5;
        28: v = 32'd3;
        29: v = 32'd1;
        default: v = 32'd0;
      endcase
      atan_step = signed'({{(ZW-32){1'b0}}, v});
    end
  endfunction

endpackage
`default_nettype wire

FILE: rtl/e2q_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// e2q_cordic
// Three-lane rotation pipeline giving sine and cosine of the half angles,
// one rotation step per register stage.
// ----------------------------------------------------------------------------
module e2q_cordic (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic adv,
  input  wire logic in_valid,
  input  wire logic [e2q_pkg::FIELD_W-1:0] angle [3],
  output logic signed [e2q_pkg::XW-1:0] sin_out [3],
  output logic signed [e2q_pkg::XW-1:0] cos_out [3],
  output logic out_valid
);

  localparam int N  = e2q_pkg::STEPS;
  localparam int XW = e2q_pkg::XW;
  localparam int ZW = e2q_pkg::ZW;
  localparam int AB = e2q_pkg::ANGLE_BITS;

  logic signed [XW-1:0] xs [3][N+1];
  logic signed [XW-1:0] ys [3][N+1];
  logic signed [ZW-1:0] zs [3][N+1];
  logic [N:0] vld;

  // Valid bits travel with the data and move only when the pipe advances.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[N-1:0], in_valid};
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [31:0] raw_ext;
    logic signed [ZW-1:0] z_init;

    // Sign-extend the binary angle and scale it to a half angle.
    assign raw_ext = {{(32-e2q_pkg::FIELD_W){1'b0}}, angle[l]};
    assign z_init  = ZW'(signed'(raw_ext[AB-1:0])) <<< (31 - AB);

    always_ff @(posedge clk) begin
      if (adv) begin
        xs[l][0] <= e2q_pkg::CORDIC_GAIN;
        ys[l][0] <= '0;
        zs[l][0] <= z_init;
      end
    end

    for (genvar s = 0; s < N; s++) begin : g_step
      // One rotation step: turn toward zero residual angle.
      always_ff @(posedge clk) begin
        if (adv) begin
          if (!zs[l][s][ZW-1]) begin
            xs[l][s+1] <= xs[l][s] - (ys[l][s] >>> s);
            ys[l][s+1] <= ys[l][s] + (xs[l][s] >>> s);
            zs[l][s+1] <= zs[l][s] - e2q_pkg::atan_step(s);
          end else begin
            xs[l][s+1] <= xs[l][s] + (ys[l][s] >>> s);
            ys[l][s+1] <= ys[l][s] - (xs[l][s] >>> s);
            zs[l][s+1] <= zs[l][s] + e2q_pkg::atan_step(s);
          end
        end
      end
    end

    assign sin_out[l] = ys[l][N];
    assign cos_out[l] = xs[l][N];
  end

  assign out_valid = vld[N];

endmodule
`default_nettype wire

FILE: rtl/e2q_combine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// e2q_combine
// Forms the four quaternion components from triple products in four stages:
// pair products, rounding, triple products, then sum, round and saturate.
// ----------------------------------------------------------------------------
module e2q_combine (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic adv,
  input  wire logic in_valid,
  input  wire logic signed [e2q_pkg::XW-1:0] sr,
  input  wire logic signed [e2q_pkg::XW-1:0] cr,
  input  wire logic signed [e2q_pkg::XW-1:0] sp,
  input  wire logic signed [e2q_pkg::XW-1:0] cp,
  input  wire logic signed [e2q_pkg::XW-1:0] sy,
  input  wire logic signed [e2q_pkg::XW-1:0] cy,
  output logic [e2q_pkg::FIELD_W-1:0] quat [4],
  output logic out_valid
);

  localparam int XW = e2q_pkg::XW;
  localparam int PW = e2q_pkg::PW;
  localparam int SW = e2q_pkg::SW;
  localparam int WF = e2q_pkg::WORK_FRAC;
  localparam int FS = e2q_pkg::FIN_SHIFT;
  localparam logic signed [PW-1:0] RND_W = PW'(1) <<< (WF - 1);
  localparam logic signed [SW-1:0] RND_F = SW'(1) <<< (FS - 1);
  localparam logic signed [SW-1:0] LIM   = SW'(e2q_pkg::SAT_LIM);
  localparam logic signed [SW-1:0] NLIM  = -LIM;

  logic [3:0] vld;
  logic signed [PW-1:0] p_cc, p_cs, p_sc, p_ss;
  logic signed [XW-1:0] cc, cs, sc, ss;
  logic signed [XW-1:0] sy1, cy1, sy2, cy2;
  logic signed [PW-1:0] t_cs_sy, t_sc_cy, t_cs_cy, t_sc_sy;
  logic signed [PW-1:0] t_cc_sy, t_ss_cy, t_cc_cy, t_ss_sy;
  logic signed [SW-1:0] sum [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  // Stage one: pair products of roll and pitch terms.
  always_ff @(posedge clk) begin
    if (adv) begin
      p_cc <= cr * cp;
      p_cs <= cr * sp;
      p_sc <= sr * cp;
      p_ss <= sr * sp;
      sy1  <= sy;
      cy1  <= cy;
    end
  end

  // Stage two: round the pair products back to the working format.
  always_ff @(posedge clk) begin
    if (adv) begin
      cc  <= XW'((p_cc + RND_W) >>> WF);
      cs  <= XW'((p_cs + RND_W) >>> WF);
      sc  <= XW'((p_sc + RND_W) >>> WF);
      ss  <= XW'((p_ss + RND_W) >>> WF);
      sy2 <= sy1;
      cy2 <= cy1;
    end
  end

  // Stage three: triple products with the yaw terms.
  always_ff @(posedge clk) begin
    if (adv) begin
      t_cs_sy <= cs * sy2;
      t_sc_cy <= sc * cy2;
      t_cs_cy <= cs * cy2;
      t_sc_sy <= sc * sy2;
      t_cc_sy <= cc * sy2;
      t_ss_cy <= ss * cy2;
      t_cc_cy <= cc * cy2;
      t_ss_sy <= ss * sy2;
    end
  end

  // Component sums in the double working format.
  always_comb begin
    sum[0] = SW'(t_cs_sy) - SW'(t_sc_cy);
    sum[1] = -SW'(t_cs_cy) - SW'(t_sc_sy);
    sum[2] = SW'(t_cc_sy) - SW'(t_ss_cy);
    sum[3] = SW'(t_cc_cy) + SW'(t_ss_sy);
  end

  // Stage four: round to the output format and clamp symmetrically.
  for (genvar k = 0; k < 4; k++) begin : g_fin
    logic signed [SW-1:0] rv;
    assign rv = (sum[k] + RND_F) >>> FS;
    always_ff @(posedge clk) begin
      if (adv) begin
        if (rv > LIM) begin
          quat[k] <= LIM[e2q_pkg::FIELD_W-1:0];
        end else if (rv < NLIM) begin
          quat[k] <= NLIM[e2q_pkg::FIELD_W-1:0];
        end else begin
          quat[k] <= rv[e2q_pkg::FIELD_W-1:0];
        end
      end
    end
  end

  assign out_valid = vld[3];

endmodule
`default_nettype wire

FILE: rtl/euler_to_quaternion_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: one capture stage, thirty rotation stages and four product and
// rounding stages lie between input transfer and result valid.
// Throughput: one item per cycle; the whole pipe holds while a result waits.
// Reset: synchronous, clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// euler_to_quaternion_core
// Converts roll, pitch and yaw binary angles to a Q1.15 rotation quaternion.
// ----------------------------------------------------------------------------
module euler_to_quaternion_core (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic signed [15:0] roll_angle,
  input  wire logic signed [15:0] pitch_angle,
  input  wire logic signed [15:0] yaw_angle,
  output logic out_valid,
  input  wire logic out_ready,
  output logic signed [15:0] quat_x,
  output logic signed [15:0] quat_y,
  output logic signed [15:0] quat_z,
  output logic signed [15:0] quat_w
);

  localparam int XW = e2q_pkg::XW;

  logic adv;
  logic cordic_valid;
  logic [e2q_pkg::FIELD_W-1:0] angles [3];
  logic signed [XW-1:0] sn [3];
  logic signed [XW-1:0] cs [3];
  logic [e2q_pkg::FIELD_W-1:0] q [4];

  // The pipe moves unless a finished result is held by the consumer.
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  assign angles[0] = roll_angle;
  assign angles[1] = pitch_angle;
  assign angles[2] = yaw_angle;

  e2q_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (in_valid),
    .angle     (angles),
    .sin_out   (sn),
    .cos_out   (cs),
    .out_valid (cordic_valid)
  );

  e2q_combine u_combine (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (cordic_valid),
    .sr        (sn[0]),
    .cr        (cs[0]),
    .sp        (sn[1]),
    .cp        (cs[1]),
    .sy        (sn[2]),
    .cy        (cs[2]),
    .quat      (q),
    .out_valid (out_valid)
  );

  assign quat_x = q[0];
  assign quat_y = q[1];
  assign quat_z = q[2];
  assign quat_w = q[3];

  // A held result keeps the whole pipe frozen.
  a_hold_freezes: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("pipe advanced while a result was held");

  // Saturation never yields the most negative code.
  a_sat_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (quat_x != 16'sh8000 && quat_y != 16'sh8000 &&
                   quat_z != 16'sh8000 && quat_w != 16'sh8000))
    else $error("component outside saturation range");

  // A stalled result stays valid and keeps its w and x components.
  a_stall_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(quat_w) && $stable(quat_x)))
    else $error("held result changed");

endmodule
`default_nettype wire
